>>> hdl/pdc_pkg.sv
// Package for the permutation displacement counter.
// Holds sizes, the modulus, command and status structs, the FSM state type and
// the table address function. Used by every module of the block.
package pdc_pkg;

  localparam int MAX_N    = 32;
  localparam int SPAN     = 2 * MAX_N * MAX_N + 1;
  localparam int CENTER   = MAX_N * MAX_N;
  localparam int LAYER_SZ = (MAX_N + 1) * SPAN;
  localparam int DEPTH    = 2 * LAYER_SZ;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int N_W     = 6;
  localparam int TGT_W   = 11;
  localparam int CNT_W   = 30;
  localparam int NN_W    = 11;
  localparam int S_W     = 12;
  localparam int COEF_W  = 11;
  localparam int PROD_W  = CNT_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [CNT_W-1:0] MODULUS = 30'd1000000007;
  // 2^30 mod MODULUS, used to fold the upper bits back down.
  localparam logic [26:0] FOLD_C = 27'd73741817;

  // Which neighbor of the previous layer a read fetches, or the result entry.
  typedef enum logic [1:0] {
    TERM_A,
    TERM_B,
    TERM_C,
    TERM_RES
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_ADD,
    ST_FOLD,
    ST_FIX,
    ST_FINAL,
    ST_FWAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  init_wr;
    term_t term;
    logic  acc_load;
    logic  acc_add;
    logic  fold;
    logic  cell_wr;
    logic  cap;
  } cmd_t;

  typedef struct packed {
    logic size_over;
    logic s_last;
    logic j_last;
    logic i_last;
    logic n_zero;
    logic fold_done;
  } stat_t;

  // Flat table address of entry (layer, j, s index).
  function automatic logic [ADDR_W-1:0] tab_addr(input logic layer,
                                                 input logic [N_W-1:0] j,
                                                 input logic [S_W-1:0] sidx);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] row;
    base = layer ? ADDR_W'(LAYER_SZ) : '0;
    row  = ADDR_W'(j) * ADDR_W'(SPAN);
    return base + row + ADDR_W'(sidx);
  endfunction

endpackage

>>> hdl/permutation_displacement_counter_unit.sv
// Top level of the permutation displacement counter.
// Joins the controller (pdc_ctrl) and the datapath (pdc_datapath); uses pdc_pkg.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   size and target are sampled there. The block counts the permutations of
//   size elements whose total absolute displacement equals target, modulo
//   1000000007, and shows the count on count for exactly one cycle with done
//   high. The receiver cannot stall; the result must be taken in that cycle.
//   For a size above 32, the block goes straight to the result read and gives
//   zero. Otherwise it first writes one table row of 2*n*n+1 entries, then
//   updates each cell of layers 1..n, (2*n*n+1)*n*(n+3)/2 cells, each by
//   three reads through the single table read port, two accumulate steps, a
//   fold loop that reduces the sum modulo 1000000007, and the write-back.
//   Then the count is read from the table, captured and presented. One
//   request is worked on at a time; busy stays high until the cycle after done.
//   Reset returns the controller to idle; the table needs no clearing since
//   every entry is written before it is read.
module permutation_displacement_counter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pdc_pkg::N_W-1:0]     size,
  input  logic [pdc_pkg::TGT_W-1:0]   target,
  output logic                        done,
  output logic [pdc_pkg::CNT_W-1:0]   count
);

  pdc_pkg::cmd_t  cmd;
  pdc_pkg::stat_t stat;

  // Sequencer.
  pdc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Counters, table and arithmetic.
  pdc_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .size   (size),
    .target (target),
    .cmd    (cmd),
    .stat   (stat),
    .count  (count)
  );

  // A taken request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after request");

  // The result strobe lasts one cycle and frees the block.
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block still busy after result");

  // A delivered count is always reduced.
  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (count < pdc_pkg::MODULUS))
    else $error("count not reduced");

endmodule

>>> hdl/pdc_ctrl.sv
// Controller of the permutation displacement counter.
// Sequences table initialization, per-cell reads, reduction and write-back.
// Depends on pdc_pkg.
module pdc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pdc_pkg::stat_t stat,
  output pdc_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  pdc_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.term     = pdc_pkg::TERM_A;
    case (state)
      pdc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.size_over ? pdc_pkg::ST_FINAL : pdc_pkg::ST_INIT;
        end
      end
      pdc_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.s_last) begin
          state_next = stat.n_zero ? pdc_pkg::ST_FINAL : pdc_pkg::ST_RD_A;
        end
      end
      pdc_pkg::ST_RD_A: begin
        cmd.term   = pdc_pkg::TERM_A;
        state_next = pdc_pkg::ST_RD_B;
      end
      pdc_pkg::ST_RD_B: begin
        cmd.term   = pdc_pkg::TERM_B;
        state_next = pdc_pkg::ST_RD_C;
      end
      pdc_pkg::ST_RD_C: begin
        cmd.term     = pdc_pkg::TERM_C;
        cmd.acc_load = 1'b1;
        state_next   = pdc_pkg::ST_MUL;
      end
      pdc_pkg::ST_MUL: begin
        cmd.acc_add = 1'b1;
        state_next  = pdc_pkg::ST_ADD;
      end
      pdc_pkg::ST_ADD: begin
        cmd.acc_add = 1'b1;
        state_next  = pdc_pkg::ST_FOLD;
      end
      pdc_pkg::ST_FOLD: begin
        if (stat.fold_done) begin
          state_next = pdc_pkg::ST_FIX;
        end else begin
          cmd.fold = 1'b1;
        end
      end
      pdc_pkg::ST_FIX: begin
        cmd.cell_wr = 1'b1;
        if (stat.s_last && stat.j_last && stat.i_last) begin
          state_next = pdc_pkg::ST_FINAL;
        end else begin
          state_next = pdc_pkg::ST_RD_A;
        end
      end
      pdc_pkg::ST_FINAL: begin
        cmd.term   = pdc_pkg::TERM_RES;
        state_next = pdc_pkg::ST_FWAIT;
      end
      pdc_pkg::ST_FWAIT: begin
        cmd.cap    = 1'b1;
        state_next = pdc_pkg::ST_RESULT;
      end
      pdc_pkg::ST_RESULT: begin
        state_next = pdc_pkg::ST_IDLE;
      end
      default: begin
        state_next = pdc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != pdc_pkg::ST_IDLE);
  assign done = (state == pdc_pkg::ST_RESULT);

endmodule

>>> hdl/pdc_datapath.sv
// Datapath of the permutation displacement counter.
// Holds the loop counters, the two-layer table memory, the multiplier and the
// modular reduction. Depends on pdc_pkg.
module pdc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pdc_pkg::N_W-1:0]    size,
  input  logic [pdc_pkg::TGT_W-1:0]  target,
  input  pdc_pkg::cmd_t              cmd,
  output pdc_pkg::stat_t             stat,
  output logic [pdc_pkg::CNT_W-1:0]  count
);

  logic [pdc_pkg::N_W-1:0]    n, i, j;
  logic [pdc_pkg::TGT_W-1:0]  tgt;
  logic [pdc_pkg::NN_W-1:0]   nn;
  logic [pdc_pkg::S_W-1:0]    sidx, lo, hi, two_i, sq;
  logic [pdc_pkg::CNT_W-1:0]  mem [pdc_pkg::DEPTH];
  logic [pdc_pkg::CNT_W-1:0]  rd_data, res, fixed, wr_data;
  logic [pdc_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic                       vld, vld_q;
  logic [pdc_pkg::COEF_W-1:0] coef, coef_q;
  logic [pdc_pkg::PROD_W-1:0] prod;
  logic [pdc_pkg::ACC_W-1:0]  acc;
  logic [pdc_pkg::N_W:0]      jp1;
  logic [13:0]                jsq;

  assign sq    = pdc_pkg::S_W'(size * size);
  assign lo    = pdc_pkg::S_W'(pdc_pkg::CENTER) - pdc_pkg::S_W'(nn);
  assign hi    = pdc_pkg::S_W'(pdc_pkg::CENTER) + pdc_pkg::S_W'(nn);
  assign two_i = pdc_pkg::S_W'({i, 1'b0});
  assign jp1   = {1'b0, j} + 1'b1;
  assign jsq   = 14'(jp1 * jp1);

  // Status toward the controller.
  assign stat.size_over = (size > pdc_pkg::N_W'(pdc_pkg::MAX_N));
  assign stat.s_last    = (sidx == hi);
  assign stat.j_last    = (j == i);
  assign stat.i_last    = (i == n);
  assign stat.n_zero    = (n == '0);
  assign stat.fold_done = (acc[pdc_pkg::ACC_W-1:pdc_pkg::CNT_W] == '0);

  // Loop counters and query registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else if (cmd.load) begin
      n    <= size;
      tgt  <= target;
      nn   <= pdc_pkg::NN_W'(sq);
      sidx <= pdc_pkg::S_W'(pdc_pkg::CENTER) - sq;
    end else if (cmd.init_wr) begin
      if (stat.s_last) begin
        sidx <= lo;
        i    <= pdc_pkg::N_W'(1);
        j    <= '0;
      end else begin
        sidx <= sidx + 1'b1;
      end
    end else if (cmd.cell_wr) begin
      if (!stat.s_last) begin
        sidx <= sidx + 1'b1;
      end else begin
        sidx <= lo;
        if (!stat.j_last) begin
          j <= j + 1'b1;
        end else begin
          j <= '0;
          i <= i + 1'b1;
        end
      end
    end
  end

  // Read address, validity and coefficient of the selected neighbor or the result entry.
  always_comb begin
    case (cmd.term)
      pdc_pkg::TERM_A: begin
        rd_addr = pdc_pkg::tab_addr(~i[0], j, sidx);
        vld     = (j < i);
        coef    = pdc_pkg::COEF_W'({j, 1'b1});
      end
      pdc_pkg::TERM_B: begin
        rd_addr = pdc_pkg::tab_addr(~i[0], pdc_pkg::N_W'(jp1), sidx - two_i);
        vld     = (jp1 < {1'b0, i}) && (sidx >= lo + two_i);
        coef    = pdc_pkg::COEF_W'(jsq);
      end
      pdc_pkg::TERM_C: begin
        rd_addr = pdc_pkg::tab_addr(~i[0], j - 1'b1, sidx + two_i);
        vld     = (j != '0) && (sidx + two_i <= hi);
        coef    = pdc_pkg::COEF_W'(1);
      end
      default: begin
        rd_addr = pdc_pkg::tab_addr(n[0], '0,
                                    pdc_pkg::S_W'(tgt) + pdc_pkg::S_W'(pdc_pkg::CENTER));
        vld     = 1'b1;
        coef    = pdc_pkg::COEF_W'(1);
      end
    endcase
  end

  // Table memory: one registered read and one write per cycle.
  assign fixed   = (acc[pdc_pkg::CNT_W-1:0] >= pdc_pkg::MODULUS) ?
                   acc[pdc_pkg::CNT_W-1:0] - pdc_pkg::MODULUS : acc[pdc_pkg::CNT_W-1:0];
  assign wr_addr = cmd.init_wr ? pdc_pkg::tab_addr(1'b0, '0, sidx)
                               : pdc_pkg::tab_addr(i[0], j, sidx);
  assign wr_data = cmd.init_wr ?
                   pdc_pkg::CNT_W'(sidx == pdc_pkg::S_W'(pdc_pkg::CENTER)) : fixed;

  always_ff @(posedge clk) begin
    if (cmd.init_wr || cmd.cell_wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Multiply, accumulate and fold the upper bits by 2^30 mod the modulus.
  always_ff @(posedge clk) begin
    vld_q  <= vld;
    coef_q <= coef;
    prod   <= vld_q ? pdc_pkg::PROD_W'(rd_data * coef_q) : '0;
    if (cmd.acc_load) begin
      acc <= pdc_pkg::ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + pdc_pkg::ACC_W'(prod);
    end else if (cmd.fold) begin
      acc <= pdc_pkg::ACC_W'(acc[pdc_pkg::ACC_W-1:pdc_pkg::CNT_W] * pdc_pkg::FOLD_C)
           + pdc_pkg::ACC_W'(acc[pdc_pkg::CNT_W-1:0]);
    end
  end

  // Result capture; oversized queries and targets beyond n*n give zero.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      if ((n > pdc_pkg::N_W'(pdc_pkg::MAX_N)) || (tgt > nn)) begin
        res <= '0;
      end else begin
        res <= rd_data;
      end
    end
  end

  assign count = res;

endmodule

>>> tb/tb_permutation_displacement_counter_unit.sv
// Testbench for permutation_displacement_counter_unit.
// Drives size/target requests, predicts each displacement count with a
// self-contained table computation, and checks every count; uses pdc_pkg.
module tb_permutation_displacement_counter_unit;

  localparam int       CYCLE_LIMIT = 8000000;
  localparam int       DRAIN_WAIT  = 40;
  localparam longint   PRIME       = 1000000007;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [pdc_pkg::N_W-1:0]    size;
  logic [pdc_pkg::TGT_W-1:0]  target;
  logic                       done;
  logic [pdc_pkg::CNT_W-1:0]  count;

  logic [pdc_pkg::CNT_W-1:0]  count_q[$];
  int                         fail_cnt;
  int                         cycle_cnt;

  // Two rolling layers of counts, indexed by open pairs and shifted sum.
  longint unsigned   ways[0:1][0:pdc_pkg::MAX_N][0:pdc_pkg::SPAN-1];

  permutation_displacement_counter_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .size   (size),
    .target (target),
    .done   (done),
    .count  (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Number of permutations of n elements with total displacement t, mod prime.
  function automatic logic [pdc_pkg::CNT_W-1:0] footrule_count(input int n, input int t);
    int nn;
    int cur;
    int prv;
    longint unsigned acc;
    longint unsigned v;
    nn = n * n;
    if (n > pdc_pkg::MAX_N) return '0;
    for (int s = -nn; s <= nn; s++) ways[0][0][s + pdc_pkg::CENTER] = 0;
    ways[0][0][pdc_pkg::CENTER] = 1;
    for (int i = 1; i <= n; i++) begin
      cur = i & 1;
      prv = cur ^ 1;
      for (int j = 0; j <= i; j++) begin
        for (int s = -nn; s <= nn; s++) begin
          acc = 0;
          // Element stays paired as it was, or opens and closes within itself.
          if (j <= i - 1) begin
            v = ways[prv][j][s + pdc_pkg::CENTER];
            acc += v + (v * longint'(2 * j)) % PRIME;
          end
          // Two open pairs close together.
          if (j + 1 <= i - 1 && s - 2 * i >= -nn) begin
            v = ways[prv][j + 1][s - 2 * i + pdc_pkg::CENTER];
            acc += (v * longint'((j + 1) * (j + 1))) % PRIME;
          end
          // A new pair opens.
          if (j > 0 && j - 1 <= i - 1 && s + 2 * i <= nn)
            acc += ways[prv][j - 1][s + 2 * i + pdc_pkg::CENTER];
          ways[cur][j][s + pdc_pkg::CENTER] = acc % PRIME;
        end
      end
    end
    if (t > nn) return '0;
    return pdc_pkg::CNT_W'(ways[n & 1][0][t + pdc_pkg::CENTER]);
  endfunction

  // Each count is compared with the oldest prediction.
  always @(negedge clk) begin
    if (!rst && done) begin
      if (count_q.size() == 0) begin
        $error("count: no request outstanding, got %0d", count);
        fail_cnt++;
      end else begin
        logic [pdc_pkg::CNT_W-1:0] want;
        want = count_q.pop_front();
        if (count !== want) begin
          $error("count: expected %0d, actual %0d", want, count);
          fail_cnt++;
        end
      end
    end
  end

  // Send one request after a gap; start stays high so back-to-back works.
  task automatic send_request(input int n, input int t, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    size   <= pdc_pkg::N_W'(n);
    target <= pdc_pkg::TGT_W'(t);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    count_q.push_back(footrule_count(n, t));
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    wait (count_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Extremes, odd targets, targets past n*n, empty and oversized requests.
  task automatic test_directed();
    int n_list[19] = '{0, 0, 0, 1, 1, 2, 2, 3, 3, 3, 4, 5, 6, 7, 33, 63, 40, 8, 2};
    int t_list[19] = '{0, 2, 2047, 0, 1, 2, 4, 4, 3, 10, 8, 12, 18, 20, 0, 2047, 1024, 32, 6};
    for (int k = 0; k < 19; k++) send_request(n_list[k], t_list[k], k % 3);
  endtask

  // Mostly small sizes with in-range even targets; some noise and oversizes.
  task automatic test_random(input int items, input int gap_pct);
    int n;
    int t;
    int gap;
    for (int k = 0; k < items; k++) begin
      case ($urandom_range(9))
        0: n = $urandom_range(63, 33);
        1: n = $urandom_range(7);
        default: n = $urandom_range(5);
      endcase
      if ($urandom_range(3) == 0) t = $urandom_range(2047);
      else t = 2 * $urandom_range((n <= pdc_pkg::MAX_N ? n * n : 0) / 2);
      gap = ($urandom_range(99) < gap_pct) ? $urandom_range(4, 1) : 0;
      send_request(n, t, gap);
    end
  endtask

  // Sender holds off until every outstanding count is back.
  task automatic test_drain_pause();
    send_request(3, 4, 0);
    send_request(4, 6, 0);
    wait_idle();
    send_request(2, 2, 0);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    size      <= '0;
    target    <= '0;
    fail_cnt  = 0;
    cycle_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(30, 38);
    test_drain_pause();
    test_random(30, 67);
    test_random(20, 0);
    wait_idle();
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pdc_pkg.sv
hdl/pdc_ctrl.sv
hdl/pdc_datapath.sv
hdl/permutation_displacement_counter_unit.sv
tb/tb_permutation_displacement_counter_unit.sv
